/* sv/qcli_pkg.sv */
// Shared constants, types and helpers for the quadratic curve / line intersection block.
// No dependencies; compile first.
`default_nettype none

package qcli_pkg;

    // Outcome codes, also used as the result mode along the pipeline
    localparam logic [1:0] OUT_NONE    = 2'd0;
    localparam logic [1:0] OUT_OPEN_HI = 2'd1;
    localparam logic [1:0] OUT_OPEN_LO = 2'd2;
    localparam logic [1:0] OUT_TWO     = 2'd3;

    localparam int SQ_STEPS  = 32;
    localparam int DIV_STEPS = 32;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;
    localparam logic signed [35:0] SAT_MAX36 = 36'sh0_7FFF_FFFF;
    localparam logic signed [35:0] SAT_MIN36 = -36'sh0_8000_0000;

    // Curvature is negligible when |t3| * NEGL_RECIP < root + |t4|
    localparam logic [14:0] NEGL_RECIP = 15'd20000;

    typedef struct packed {
        logic signed [31:0] t4;
        logic signed [31:0] t3;
        logic signed [31:0] dwl;
        logic               solv;
    } sq_meta_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       ovf_a;
        logic       ovf_b;
        logic       neg_a;
        logic       neg_b;
    } dv_meta_t;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [31:0] r;
        if (x > SAT_MAX36)
            r = SAT_MAX;
        else if (x < SAT_MIN36)
            r = SAT_MIN;
        else
            r = x[31:0];
        return r;
    endfunction

    // Signed saturated value from a quotient magnitude, sign and overflow flag
    function automatic logic signed [31:0] quo_sat(input logic [31:0] mag, input logic neg,
                                                   input logic ovf);
        logic signed [31:0] r;
        if (neg)
            r = (ovf || mag > 32'h8000_0000) ? SAT_MIN : $signed(32'd0 - mag);
        else
            r = (ovf || mag[31]) ? SAT_MAX : $signed(mag);
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/quadratic_curve_line_intersect.sv */
// Quadratic curve / sloped line intersection, fully pipelined top level.
// Depends on qcli_pkg (constants, stage types, saturation helpers).
//
// Usage:
//   Input channel (in_valid / in_ready) carries one query item: the curve
//   coefficients lin_y, quad_y, lin_z, quad_z (Q16.16), slope_sin and
//   slope_cos (Q1.16) and line_offset (Q16.16).
//   Output channel (out_valid / out_ready) returns one item per query:
//   t_high, t_low (Q16.16, saturated extremes on an open side) and outcome.
//   Throughput is one item per cycle while the receiver does not stall:
//   every stage is a register, the square root runs as 32 one-bit stages
//   and both quotients as 32 one-bit divider stages.
//   While the receiver stalls (out_valid high, out_ready low) the whole pipe
//   holds and in_ready drops; no item is lost or repeated. The next item is
//   taken in the same cycle a waiting result is taken.
//   Reset clears every stage valid bit; the block holds no other state.
`default_nettype none

module quadratic_curve_line_intersect
    import qcli_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [31:0] lin_y,
    input  wire logic signed [31:0] quad_y,
    input  wire logic signed [31:0] lin_z,
    input  wire logic signed [31:0] quad_z,
    input  wire logic signed [17:0] slope_sin,
    input  wire logic signed [17:0] slope_cos,
    input  wire logic signed [31:0] line_offset,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [31:0]      t_high,
    output logic signed [31:0]      t_low,
    output logic [1:0]              outcome
);

    // Advance the whole pipe unless a result sits unclaimed at the output
    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- Stage 1: coefficient products ----------------
    logic               s1_v_reg;
    logic signed [49:0] s1_pc_reg, s1_ps_reg, s1_ph_reg, s1_pb_reg;
    logic signed [31:0] s1_dwl_reg;

    // ---------------- Stage 2: t4, t3 ----------------
    logic               s2_v_reg;
    logic signed [31:0] s2_t4_reg, s2_t3_reg, s2_dwl_reg;
    logic signed [50:0] d4, d3;
    assign d4 = 51'(s1_pc_reg) - 51'(s1_ps_reg);
    assign d3 = 51'(s1_ph_reg) - 51'(s1_pb_reg);

    // ---------------- Stage 3: squares and products ----------------
    logic               s3_v_reg;
    logic signed [63:0] s3_p_reg, s3_prod_reg;
    logic signed [31:0] s3_t4_reg, s3_t3_reg, s3_dwl_reg;

    // ---------------- Stage 4: discriminant ----------------
    logic               s3_neg;
    logic [63:0]        s3_absprod, s3_q, s3_det;
    logic               s3_solv;
    assign s3_neg     = s3_prod_reg[63];
    assign s3_absprod = s3_neg ? (64'd0 - s3_prod_reg) : s3_prod_reg;
    assign s3_q       = {s3_absprod[62:0], 1'b0};
    assign s3_solv    = !s3_neg || (s3_p_reg >= s3_q);
    assign s3_det     = s3_neg ? (s3_p_reg - s3_q) : (s3_p_reg + s3_q);

    // Square root pipe: index 0 is loaded from stage 3, index SQ_STEPS is the result
    logic        sq_v_reg    [0:SQ_STEPS];
    logic [33:0] sq_rem_reg  [0:SQ_STEPS];
    logic [31:0] sq_root_reg [0:SQ_STEPS];
    logic [63:0] sq_n_reg    [0:SQ_STEPS];
    sq_meta_t    sq_meta_reg [0:SQ_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            s3_v_reg     <= 1'b0;
            sq_v_reg[0]  <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg     <= in_valid;
            s2_v_reg     <= s1_v_reg;
            s3_v_reg     <= s2_v_reg;
            sq_v_reg[0]  <= s3_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_pc_reg  <= slope_cos * lin_z;
            s1_ps_reg  <= slope_sin * lin_y;
            s1_ph_reg  <= slope_cos * quad_z;
            s1_pb_reg  <= slope_sin * quad_y;
            s1_dwl_reg <= line_offset;

            s2_t4_reg  <= sat32(36'($signed(d4[50:16])));
            s2_t3_reg  <= sat32($signed(d3[50:15]));
            s2_dwl_reg <= s1_dwl_reg;

            s3_p_reg    <= s2_t4_reg * s2_t4_reg;
            s3_prod_reg <= s2_t3_reg * s2_dwl_reg;
            s3_t4_reg   <= s2_t4_reg;
            s3_t3_reg   <= s2_t3_reg;
            s3_dwl_reg  <= s2_dwl_reg;

            sq_rem_reg[0]       <= '0;
            sq_root_reg[0]      <= '0;
            sq_n_reg[0]         <= s3_det;
            sq_meta_reg[0].t4   <= s3_t4_reg;
            sq_meta_reg[0].t3   <= s3_t3_reg;
            sq_meta_reg[0].dwl  <= s3_dwl_reg;
            sq_meta_reg[0].solv <= s3_solv;
        end
    end

    // One root bit per stage: bring down two bits, try (root << 2) | 1
    genvar gi;
    generate
        for (gi = 0; gi < SQ_STEPS; gi++)
        begin : g_sq
            logic [35:0] wk, trial;
            logic        ge;
            logic [33:0] rem_next;
            logic [31:0] root_next;
            assign wk        = {sq_rem_reg[gi], sq_n_reg[gi][63:62]};
            assign trial     = {2'b00, sq_root_reg[gi], 2'b01};
            assign ge        = wk >= trial;
            assign rem_next  = ge ? 34'(wk - trial) : wk[33:0];
            assign root_next = {sq_root_reg[gi][30:0], ge};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sq_v_reg[gi+1] <= 1'b0;
                else if (en)
                    sq_v_reg[gi+1] <= sq_v_reg[gi];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_rem_reg[gi+1]  <= rem_next;
                    sq_root_reg[gi+1] <= root_next;
                    sq_n_reg[gi+1]    <= {sq_n_reg[gi][61:0], 2'b00};
                    sq_meta_reg[gi+1] <= sq_meta_reg[gi];
                end
            end
        end
    endgenerate

    // ---------------- Stage 5: curvature test, pick numerators and divisor ----------------
    sq_meta_t           sm;
    logic [31:0]        root, at4, at3;
    logic [46:0]        negl_lhs;
    logic [33:0]        negl_rhs;
    logic               negl;
    logic signed [34:0] num_a_next, num_b_next, root_s;
    logic signed [31:0] den_next;
    logic [1:0]         mode_next;

    assign sm       = sq_meta_reg[SQ_STEPS];
    assign root     = sq_root_reg[SQ_STEPS];
    assign at4      = sm.t4[31] ? (32'd0 - sm.t4) : sm.t4;
    assign at3      = sm.t3[31] ? (32'd0 - sm.t3) : sm.t3;
    assign negl_lhs = at3 * NEGL_RECIP;
    assign negl_rhs = {2'b00, root} + {2'b00, at4};
    assign negl     = negl_lhs < 47'(negl_rhs);
    assign root_s   = $signed({3'b000, root});

    always_comb
    begin
        num_a_next = negl ? 35'(sm.dwl) : (root_s - 35'(sm.t4));
        num_b_next = root_s + 35'(sm.t4);
        den_next   = negl ? sm.t4 : sm.t3;
        if (!sm.solv)
            mode_next = OUT_NONE;
        else if (negl)
        begin
            if (sm.t4 > 32'sd0)
                mode_next = OUT_OPEN_HI;
            else if (sm.t4 < 32'sd0)
                mode_next = OUT_OPEN_LO;
            else
                mode_next = OUT_NONE;
        end
        else if (sm.t3 != 32'sd0)
            mode_next = OUT_TWO;
        else
            mode_next = OUT_NONE;
    end

    logic               s5_v_reg;
    logic signed [34:0] s5_num_a_reg, s5_num_b_reg;
    logic signed [31:0] s5_den_reg;
    logic [1:0]         s5_mode_reg;

    // ---------------- Stage 6: magnitudes, overflow check, divider load ----------------
    logic [34:0] ma, mb;
    logic [48:0] dvd_a, dvd_b;
    logic [31:0] md;
    assign ma    = s5_num_a_reg[34] ? (35'd0 - s5_num_a_reg) : s5_num_a_reg;
    assign mb    = s5_num_b_reg[34] ? (35'd0 - s5_num_b_reg) : s5_num_b_reg;
    assign md    = s5_den_reg[31] ? (32'd0 - s5_den_reg) : s5_den_reg;
    assign dvd_a = {ma[32:0], 16'd0};
    assign dvd_b = {mb[32:0], 16'd0};

    logic        dv_v_reg    [0:DIV_STEPS];
    logic [31:0] dv_rem_a_reg[0:DIV_STEPS];
    logic [31:0] dv_rem_b_reg[0:DIV_STEPS];
    logic [31:0] dv_lo_a_reg [0:DIV_STEPS];
    logic [31:0] dv_lo_b_reg [0:DIV_STEPS];
    logic [31:0] dv_q_a_reg  [0:DIV_STEPS];
    logic [31:0] dv_q_b_reg  [0:DIV_STEPS];
    logic [31:0] dv_md_reg   [0:DIV_STEPS];
    dv_meta_t    dv_meta_reg [0:DIV_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_v_reg    <= 1'b0;
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s5_v_reg    <= sq_v_reg[SQ_STEPS];
            dv_v_reg[0] <= s5_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_num_a_reg <= num_a_next;
            s5_num_b_reg <= num_b_next;
            s5_den_reg   <= den_next;
            s5_mode_reg  <= mode_next;

            // Quotient reaches 2^32 exactly when the top dividend bits reach the divisor
            dv_rem_a_reg[0]      <= 32'(dvd_a[48:32]);
            dv_rem_b_reg[0]      <= 32'(dvd_b[48:32]);
            dv_lo_a_reg[0]       <= dvd_a[31:0];
            dv_lo_b_reg[0]       <= dvd_b[31:0];
            dv_q_a_reg[0]        <= '0;
            dv_q_b_reg[0]        <= '0;
            dv_md_reg[0]         <= md;
            dv_meta_reg[0].mode  <= s5_mode_reg;
            dv_meta_reg[0].ovf_a <= 32'(dvd_a[48:32]) >= md;
            dv_meta_reg[0].ovf_b <= 32'(dvd_b[48:32]) >= md;
            dv_meta_reg[0].neg_a <= s5_num_a_reg[34] ^ s5_den_reg[31];
            dv_meta_reg[0].neg_b <= s5_num_b_reg[34] ^ s5_den_reg[31];
        end
    end

    // One quotient bit per stage for both dividers
    generate
        for (gi = 0; gi < DIV_STEPS; gi++)
        begin : g_div
            logic [32:0] wa, wb, dext;
            logic        ga, gb;
            assign dext = {1'b0, dv_md_reg[gi]};
            assign wa   = {dv_rem_a_reg[gi], dv_lo_a_reg[gi][31]};
            assign wb   = {dv_rem_b_reg[gi], dv_lo_b_reg[gi][31]};
            assign ga   = wa >= dext;
            assign gb   = wb >= dext;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_v_reg[gi+1] <= 1'b0;
                else if (en)
                    dv_v_reg[gi+1] <= dv_v_reg[gi];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_a_reg[gi+1] <= ga ? 32'(wa - dext) : wa[31:0];
                    dv_rem_b_reg[gi+1] <= gb ? 32'(wb - dext) : wb[31:0];
                    dv_lo_a_reg[gi+1]  <= {dv_lo_a_reg[gi][30:0], 1'b0};
                    dv_lo_b_reg[gi+1]  <= {dv_lo_b_reg[gi][30:0], 1'b0};
                    dv_q_a_reg[gi+1]   <= {dv_q_a_reg[gi][30:0], ga};
                    dv_q_b_reg[gi+1]   <= {dv_q_b_reg[gi][30:0], gb};
                    dv_md_reg[gi+1]    <= dv_md_reg[gi];
                    dv_meta_reg[gi+1]  <= dv_meta_reg[gi];
                end
            end
        end
    endgenerate

    // ---------------- Stage 7: saturate quotients ----------------
    dv_meta_t           dm;
    logic signed [31:0] qa, qb;
    assign dm = dv_meta_reg[DIV_STEPS];
    assign qa = quo_sat(dv_q_a_reg[DIV_STEPS], dm.neg_a, dm.ovf_a);
    assign qb = quo_sat(dv_q_b_reg[DIV_STEPS], dm.neg_b, dm.ovf_b);

    logic               s7_v_reg;
    logic signed [31:0] s7_ra_reg, s7_rb_reg;
    logic [1:0]         s7_mode_reg;

    // ---------------- Stage 8: order roots, build result item ----------------
    logic signed [31:0] th_next, tl_next;
    always_comb
    begin
        case (s7_mode_reg)
            OUT_NONE:
            begin
                th_next = SAT_MAX;
                tl_next = SAT_MIN;
            end
            OUT_OPEN_HI:
            begin
                th_next = SAT_MAX;
                tl_next = s7_ra_reg;
            end
            OUT_OPEN_LO:
            begin
                th_next = s7_ra_reg;
                tl_next = SAT_MIN;
            end
            default:
            begin
                if (s7_rb_reg > s7_ra_reg)
                begin
                    th_next = s7_rb_reg;
                    tl_next = s7_ra_reg;
                end
                else
                begin
                    th_next = s7_ra_reg;
                    tl_next = s7_rb_reg;
                end
            end
        endcase
    end

    logic signed [31:0] t_high_reg, t_low_reg;
    logic [1:0]         outcome_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s7_v_reg      <= dv_v_reg[DIV_STEPS];
            out_valid_reg <= s7_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s7_ra_reg   <= qa;
            // Second root is the negated saturated quotient, saturated again
            s7_rb_reg   <= (qb == SAT_MIN) ? SAT_MAX : (32'sd0 - qb);
            s7_mode_reg <= dm.mode;
            t_high_reg  <= th_next;
            t_low_reg   <= tl_next;
            outcome_reg <= s7_mode_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign t_high    = t_high_reg;
    assign t_low     = t_low_reg;
    assign outcome   = outcome_reg;

endmodule

`default_nettype wire
